/* rtl/uvdc_pkg.sv */
// Shared types and constants for the lamp exposure controller.
// Used by uvdc_cfg_regs and uv_dose_exposure_controller_top; depends on nothing.
package uvdc_pkg;

	localparam int ADC_BITS = 12;
	localparam int GAIN_W   = 16;
	localparam int PROD_W   = ADC_BITS + GAIN_W;
	localparam int CNT_W    = 9;
	localparam int CNT_N_W  = CNT_W + 1;
	localparam int LIMIT_W  = 24;
	localparam int LPROD_W  = LIMIT_W + CNT_N_W;
	localparam int TGT_W    = 26;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 24;

	typedef enum logic [IDX_W-1:0] {
		REG_DOSE_SETTING   = 3'd0,
		REG_GAIN_PER_CODE  = 3'd1,
		REG_MAX_SAMPLES    = 3'd2,
		REG_SETTLE_SAMPLES = 3'd3,
		REG_AVG_LIMIT      = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_STOP    = 3'd1,
		ST_TIMEOUT = 3'd2,
		ST_NOLIGHT = 3'd3,
		ST_HIGH    = 3'd4
	} status_t;

	localparam logic [3:0]         RST_DOSE_SETTING   = 4'd0;
	localparam logic [GAIN_W-1:0]  RST_GAIN_PER_CODE  = 16'd330;
	localparam logic [CNT_W-1:0]   RST_MAX_SAMPLES    = 9'd300;
	localparam logic [7:0]         RST_SETTLE_SAMPLES = 8'd3;
	localparam logic [LIMIT_W-1:0] RST_AVG_LIMIT      = 24'd327680;

	typedef struct packed {
		logic                kind;
		logic                start_pressed;
		logic                stop_pressed;
		logic [ADC_BITS-1:0] adc_code;
	} in_t;

	typedef struct packed {
		logic             coil_on;
		logic             indicator_on;
		logic             led_ok;
		logic             led_fail;
		logic             busy_res;
		logic             run_done;
		logic [2:0]       end_code;
		logic [CNT_W-1:0] tick_total;
		logic [31:0]      dose_sum;
	} out_t;

	typedef struct packed {
		logic [3:0]         dose_setting;
		logic [GAIN_W-1:0]  gain_per_code;
		logic [CNT_W-1:0]   max_samples;
		logic [7:0]         settle_samples;
		logic [LIMIT_W-1:0] avg_limit;
	} cfg_t;

	// target = 10^(bit3+1) * (low three bits + 1), in Q10.16
	function automatic logic [TGT_W-1:0] target_q16(input logic [3:0] setting);
		logic [9:0] mult;
		logic [9:0] base;
		mult = setting[3] ? 10'd100 : 10'd10;
		base = 10'(mult * (10'(setting[2:0]) + 10'd1));
		return {base, 16'b0};
	endfunction

endpackage

/* rtl/uvdc_cfg_regs.sv */
// Configuration register file of the lamp exposure controller.
// Depends on uvdc_pkg for the register indexes, reset values and cfg_t.
module uvdc_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [uvdc_pkg::IDX_W-1:0] wr_index,
	input  logic [uvdc_pkg::CFG_W-1:0] wr_data,
	output uvdc_pkg::cfg_t             cfg
);
	import uvdc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dose_setting   <= RST_DOSE_SETTING;
			cfg_q.gain_per_code  <= RST_GAIN_PER_CODE;
			cfg_q.max_samples    <= RST_MAX_SAMPLES;
			cfg_q.settle_samples <= RST_SETTLE_SAMPLES;
			cfg_q.avg_limit      <= RST_AVG_LIMIT;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DOSE_SETTING:   cfg_q.dose_setting   <= wr_data[3:0];
				REG_GAIN_PER_CODE:  cfg_q.gain_per_code  <= wr_data[GAIN_W-1:0];
				REG_MAX_SAMPLES:    cfg_q.max_samples    <= wr_data[CNT_W-1:0];
				REG_SETTLE_SAMPLES: cfg_q.settle_samples <= wr_data[7:0];
				REG_AVG_LIMIT:      cfg_q.avg_limit      <= wr_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/uv_dose_exposure_controller_top.sv */
// Top level of the lamp exposure controller.
// Depends on uvdc_pkg and uvdc_cfg_regs.

// One result per request. A request is registered together with its gain-times-code
// product; when it advances, the run state is updated (dose add with saturation, average
// limit product, ordered end checks) and the output register is loaded. A new request
// can be taken every cycle while results are taken. The output register lets one more
// request in while a result waits; after that the input stalls until the result is
// taken. The dose accumulator is DOSE_BITS wide and dose_sum shows its low 32 bits.
// Configuration writes are taken every cycle and should be made only when no request is
// in flight.
module uv_dose_exposure_controller_top #(
	parameter int DOSE_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  uvdc_pkg::in_t              in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output uvdc_pkg::out_t             out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [uvdc_pkg::IDX_W-1:0] cfg_index,
	input  logic [uvdc_pkg::CFG_W-1:0] cfg_data
);
	import uvdc_pkg::*;

	localparam int SUM_W = ((DOSE_BITS > PROD_W) ? DOSE_BITS : PROD_W) + 1;
	localparam int CMP_W = (DOSE_BITS > LPROD_W) ? DOSE_BITS : LPROD_W;
	localparam logic [DOSE_BITS-1:0] DOSE_MAX = {DOSE_BITS{1'b1}};

	cfg_t cfg;

	uvdc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign cfg_ready = 1'b1;

	// input stage
	logic              valid_s1;
	in_t               item_s1;
	logic [PROD_W-1:0] add_s1;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
			add_s1  <= PROD_W'(in_data.adc_code) * PROD_W'(cfg.gain_per_code);
		end
	end

	// run state
	logic                 armed_q, running_q, lamp_q, blink_q, ok_q, fail_q;
	logic [CNT_W-1:0]     tick_q;
	logic [DOSE_BITS-1:0] dose_q;
	status_t              status_q;

	logic                 armed_d, running_d, lamp_d, blink_d, ok_d, fail_d, done_d;
	logic [CNT_W-1:0]     tick_d;
	logic [DOSE_BITS-1:0] dose_d;
	status_t              status_d;

	logic [CNT_N_W-1:0]   tick_n;
	logic [SUM_W-1:0]     sum;
	logic [DOSE_BITS-1:0] dose_n;
	logic [LPROD_W-1:0]   limit_n;
	logic                 too_high;
	logic                 reached;
	logic                 fault;

	always_comb begin
		tick_n   = CNT_N_W'(tick_q) + CNT_N_W'(1);
		sum      = SUM_W'(dose_q) + SUM_W'(add_s1);
		dose_n   = (sum > SUM_W'(DOSE_MAX)) ? DOSE_MAX : DOSE_BITS'(sum);
		limit_n  = LPROD_W'(cfg.avg_limit) * LPROD_W'(tick_n);
		too_high = CMP_W'(dose_n) > CMP_W'(limit_n);
		reached  = CMP_W'(dose_n) >= CMP_W'(target_q16(cfg.dose_setting));
		fault    = (tick_n > CNT_N_W'(cfg.settle_samples))
			&& ((item_s1.adc_code == '0) || too_high);

		armed_d   = armed_q;
		running_d = running_q;
		lamp_d    = lamp_q;
		blink_d   = blink_q;
		ok_d      = ok_q;
		fail_d    = fail_q;
		tick_d    = tick_q;
		dose_d    = dose_q;
		status_d  = status_q;
		done_d    = 1'b0;

		if (!item_s1.kind) begin
			if (!running_q && item_s1.start_pressed) begin
				if (armed_q) begin
					running_d = 1'b1;
					lamp_d    = 1'b1;
					blink_d   = 1'b1;
					ok_d      = 1'b0;
					fail_d    = 1'b0;
					tick_d    = '0;
					dose_d    = '0;
					status_d  = ST_OK;
				end else begin
					armed_d = 1'b1;
				end
			end
		end else if (running_q) begin
			blink_d = !blink_q;
			tick_d  = tick_n[CNT_N_W-1] ? {CNT_W{1'b1}} : tick_n[CNT_W-1:0];
			dose_d  = dose_n;
			done_d  = 1'b1;
			priority if (item_s1.stop_pressed) begin
				status_d = ST_STOP;
			end else if (tick_n > CNT_N_W'(cfg.max_samples)) begin
				status_d = ST_TIMEOUT;
			end else if (fault) begin
				status_d = too_high ? ST_HIGH : ST_NOLIGHT;
			end else if (reached) begin
				status_d = ST_OK;
			end else begin
				done_d = 1'b0;
			end
			// end of run: drop the lamp and disarm
			if (done_d) begin
				lamp_d    = 1'b0;
				running_d = 1'b0;
				armed_d   = 1'b0;
				if (status_d == ST_OK) begin
					blink_d = 1'b0;
					ok_d    = 1'b1;
				end else begin
					blink_d = 1'b1;
					fail_d  = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			running_q <= 1'b0;
			lamp_q    <= 1'b0;
			blink_q   <= 1'b0;
			ok_q      <= 1'b0;
			fail_q    <= 1'b0;
			tick_q    <= '0;
			dose_q    <= '0;
			status_q  <= ST_OK;
		end else if (advance) begin
			armed_q   <= armed_d;
			running_q <= running_d;
			lamp_q    <= lamp_d;
			blink_q   <= blink_d;
			ok_q      <= ok_d;
			fail_q    <= fail_d;
			tick_q    <= tick_d;
			dose_q    <= dose_d;
			status_q  <= status_d;
		end
	end

	// output register
	logic out_valid_q;
	out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.coil_on      <= lamp_d;
			out_q.indicator_on <= blink_d;
			out_q.led_ok       <= ok_d;
			out_q.led_fail     <= fail_d;
			out_q.busy_res     <= running_d;
			out_q.run_done     <= done_d;
			out_q.end_code     <= status_d;
			out_q.tick_total   <= tick_d;
			out_q.dose_sum     <= 32'(dose_d);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_run_armed: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> armed_q)
		else $error("run in progress without armed");

	a_lamp_run: assert property (@(posedge clk) disable iff (!arst_n)
		lamp_q == running_q)
		else $error("lamp state differs from run state");

	a_leds_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ok_q && fail_q))
		else $error("success and failure LEDs both set");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.run_done) |-> (!out_data.busy_res && !out_data.coil_on))
		else $error("run ended but still shown busy");

	a_busy_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.busy_res) |-> (out_data.end_code == ST_OK))
		else $error("status not clear during a run");

endmodule

/* test/tb_uv_dose_exposure_controller_top.sv */
// Self-checking testbench for uv_dose_exposure_controller_top.
// A scoreboard class predicts each result from the accepted requests and the register settings.
// Depends on uvdc_pkg and the controller RTL.
module tb_uv_dose_exposure_controller_top;
	import uvdc_pkg::*;

	localparam int DOSE_BITS      = 32;
	localparam int HALF_PERIOD    = 6;
	localparam int RAND_PHASES    = 8;
	localparam int PHASE_ITEMS    = 62;
	localparam int LONG_HOLD      = 80;
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_CYCLES     = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	class dose_run_tracker;
		logic [3:0]         dose_sel;
		logic [GAIN_W-1:0]  gain;
		logic [CNT_W-1:0]   max_cnt;
		logic [7:0]         settle_cnt;
		logic [LIMIT_W-1:0] avg_lim;

		bit             armed, running, lamp, blink, ok_led, fail_led;
		logic [CNT_W-1:0] ticks;
		logic [63:0]    dose;
		logic [63:0]    dose_cap;
		status_t        status;

		out_t expected_outputs[$];
		int   errors;
		int   requests;
		int   results;
		int   ended[5];

		function new(int dose_bits);
			dose_cap   = (64'd1 << dose_bits) - 64'd1;
			dose_sel   = RST_DOSE_SETTING;
			gain       = RST_GAIN_PER_CODE;
			max_cnt    = RST_MAX_SAMPLES;
			settle_cnt = RST_SETTLE_SAMPLES;
			avg_lim    = RST_AVG_LIMIT;
			armed = 0; running = 0; lamp = 0; blink = 0; ok_led = 0; fail_led = 0;
			ticks  = '0;
			dose   = '0;
			status = ST_OK;
			errors = 0; requests = 0; results = 0;
			foreach (ended[i]) ended[i] = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_DOSE_SETTING:   dose_sel   = v[3:0];
				REG_GAIN_PER_CODE:  gain       = v[GAIN_W-1:0];
				REG_MAX_SAMPLES:    max_cnt    = v[CNT_W-1:0];
				REG_SETTLE_SAMPLES: settle_cnt = v[7:0];
				REG_AVG_LIMIT:      avg_lim    = v[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [63:0] goal_q16();
			logic [63:0] mult;
			mult = dose_sel[3] ? 64'd100 : 64'd10;
			return (mult * (64'(dose_sel[2:0]) + 64'd1)) << 16;
		endfunction

		function void close_run(status_t st, bit success);
			lamp    = 0;
			running = 0;
			armed   = 0;
			status  = st;
			blink   = !success;
			if (success) ok_led = 1;
			else fail_led = 1;
			ended[int'(st)]++;
		endfunction

		function void note_request(in_t req);
			out_t        want;
			logic [63:0] n;
			logic [63:0] add;
			logic [63:0] lim_prod;
			bit          done;
			done = 0;
			requests++;
			if (!req.kind) begin
				if (!running && req.start_pressed) begin
					if (armed) begin
						running  = 1;
						lamp     = 1;
						blink    = 1;
						ok_led   = 0;
						fail_led = 0;
						ticks    = '0;
						dose     = '0;
						status   = ST_OK;
					end else begin
						armed = 1;
					end
				end
			end else if (running) begin
				n        = 64'(ticks) + 64'd1;
				add      = 64'(gain) * 64'(req.adc_code);
				blink    = !blink;
				// count is compared at full width but held at its top value
				ticks    = (n > 64'd511) ? 9'd511 : n[CNT_W-1:0];
				dose     = (add > dose_cap - dose) ? dose_cap : dose + add;
				lim_prod = 64'(avg_lim) * n;
				done     = 1;
				if (req.stop_pressed)
					close_run(ST_STOP, 0);
				else if (n > 64'(max_cnt))
					close_run(ST_TIMEOUT, 0);
				else if (n > 64'(settle_cnt) && (req.adc_code == '0 || dose > lim_prod))
					close_run((dose > lim_prod) ? ST_HIGH : ST_NOLIGHT, 0);
				else if (dose >= goal_q16())
					close_run(ST_OK, 1);
				else
					done = 0;
			end
			want.coil_on      = lamp;
			want.indicator_on = blink;
			want.led_ok       = ok_led;
			want.led_fail     = fail_led;
			want.busy_res     = running;
			want.run_done     = done;
			want.end_code     = status;
			want.tick_total   = ticks;
			want.dose_sum     = dose[31:0];
			expected_outputs.push_back(want);
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_t got);
			out_t want;
			results++;
			if (expected_outputs.size() == 0) begin
				$error("result with no request outstanding: %h", got);
				errors++;
				return;
			end
			want = expected_outputs.pop_front();
			compare_field("coil_on", 64'(want.coil_on), 64'(got.coil_on));
			compare_field("indicator_on", 64'(want.indicator_on), 64'(got.indicator_on));
			compare_field("led_ok", 64'(want.led_ok), 64'(got.led_ok));
			compare_field("led_fail", 64'(want.led_fail), 64'(got.led_fail));
			compare_field("busy_res", 64'(want.busy_res), 64'(got.busy_res));
			compare_field("run_done", 64'(want.run_done), 64'(got.run_done));
			compare_field("end_code", 64'(want.end_code), 64'(got.end_code));
			compare_field("tick_total", 64'(want.tick_total), 64'(got.tick_total));
			compare_field("dose_sum", 64'(want.dose_sum), 64'(got.dose_sum));
		endfunction

		function int pending();
			return expected_outputs.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_t              in_data;
	logic             out_valid;
	logic             out_ready;
	out_t             out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	dose_run_tracker sb;
	bit              hold_req;
	int              quiet;
	int              settings_loaded;

	uv_dose_exposure_controller_top #(.DOSE_BITS(DOSE_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic in_t make_req(bit kind, bit start, bit stop, logic [ADC_BITS-1:0] code);
		in_t r;
		r.kind          = kind;
		r.start_pressed = start;
		r.stop_pressed  = stop;
		r.adc_code      = code;
		return r;
	endfunction

	function automatic logic [ADC_BITS-1:0] rand_code();
		case ($urandom_range(15))
			0:       return '0;
			1:       return '1;
			2:       return ADC_BITS'($urandom_range(1, 15));
			default: return ADC_BITS'($urandom_range(1, 4095));
		endcase
	endfunction

	// well-formed traffic: start polls while idle, ticks while running, some noise
	function automatic in_t rand_request(bit run_now);
		in_t r;
		int  roll;
		roll = $urandom_range(99);
		r = make_req(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
			ADC_BITS'($urandom));
		if (roll < 12) return r;
		if (!run_now) begin
			r.kind          = 1'b0;
			r.start_pressed = ($urandom_range(7) != 0);
		end else begin
			r.kind         = 1'b1;
			r.stop_pressed = ($urandom_range(29) == 0);
			r.adc_code     = rand_code();
		end
		return r;
	endfunction

	function automatic cfg_t rand_settings(int phase);
		cfg_t        s;
		logic [63:0] lim;
		case (phase)
			0: s = '{dose_setting: 4'hF, gain_per_code: '1, max_samples: '1,
				settle_samples: '1, avg_limit: '1};
			1: s = '{dose_setting: 4'h0, gain_per_code: 16'd1, max_samples: 9'd1,
				settle_samples: '0, avg_limit: '0};
			default: begin
				s.dose_setting  = 4'($urandom_range(15));
				s.gain_per_code = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535))
					: 16'($urandom_range(1, 600));
				s.max_samples    = ($urandom_range(5) == 0) ? 9'd511 : 9'($urandom_range(1, 60));
				s.settle_samples = ($urandom_range(5) == 0) ? 8'd255 : 8'($urandom_range(0, 8));
				lim = 64'(s.gain_per_code) * 64'($urandom_range(1200, 4095));
				case ($urandom_range(4))
					0:       s.avg_limit = '1;
					1:       s.avg_limit = LIMIT_W'($urandom);
					default: s.avg_limit = (lim > 64'hFFFFFF) ? '1 : lim[LIMIT_W-1:0];
				endcase
			end
		endcase
		return s;
	endfunction

	task automatic push_request(in_t req, bit with_gaps);
		int g;
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req);
		if (with_gaps) begin
			g = idle_len();
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic load_settings(cfg_t s);
		reg_idx_t         regs[5];
		logic [CFG_W-1:0] vals[5];
		regs = '{REG_DOSE_SETTING, REG_GAIN_PER_CODE, REG_MAX_SAMPLES,
			REG_SETTLE_SAMPLES, REG_AVG_LIMIT};
		vals = '{CFG_W'(s.dose_setting), CFG_W'(s.gain_per_code), CFG_W'(s.max_samples),
			CFG_W'(s.settle_samples), CFG_W'(s.avg_limit)};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	// hold the input until every outstanding result is back
	task automatic drain(bit with_pause);
		if (sb.pending() == 0 && !with_pause) return;
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		if (with_pause) repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic poll(bit start);
		push_request(make_req(1'b0, start, 1'b0, '0), 1'b1);
	endtask

	task automatic tick(bit stop, logic [ADC_BITS-1:0] code);
		push_request(make_req(1'b1, 1'b0, stop, code), 1'b1);
	endtask

	initial begin : result_sink
		int g;
		int n;
		out_ready = 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			g = idle_len();
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1'b1;
			// cut the ready stretch short when a long hold is requested
			n = $urandom_range(1, ($urandom_range(9) == 0) ? 120 : 24);
			do begin
				@(posedge clk);
				n--;
			end while (n > 0 && !hold_req);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		sb = new(DOSE_BITS);
		hold_req        = 0;
		quiet           = 0;
		settings_loaded = 0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: polls and ticks while idle, arming, ignored poll, stop, success
		poll(1'b0);
		tick(1'b1, '1);
		poll(1'b1);
		tick(1'b0, '1);
		poll(1'b1);
		poll(1'b1);
		tick(1'b0, '0);
		tick(1'b1, '1);
		poll(1'b1);
		poll(1'b1);
		tick(1'b0, '1);
		drain(1'b1);

		// timeout after two samples
		load_settings('{dose_setting: 4'hF, gain_per_code: 16'd1, max_samples: 9'd2,
			settle_samples: 8'd255, avg_limit: '1});
		poll(1'b1);
		poll(1'b1);
		repeat (3) tick(1'b0, '1);
		drain(1'b1);

		// both health faults at once, then dark sensor
		load_settings('{dose_setting: 4'hF, gain_per_code: '1, max_samples: 9'd511,
			settle_samples: 8'd1, avg_limit: '0});
		poll(1'b1);
		poll(1'b1);
		tick(1'b0, 12'd5);
		tick(1'b0, '0);
		poll(1'b1);
		poll(1'b1);
		tick(1'b0, '0);
		tick(1'b0, '0);
		drain(1'b1);

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			load_settings(rand_settings(phase));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (phase == 3 && k == 20) hold_req = 1;
				if (phase == 5 && k == 30) drain(1'b0);
				push_request(rand_request(sb.running), !(phase == 2 || phase == 6));
			end
			drain(1'b1);
		end
		repeat (END_CYCLES) @(posedge clk);

		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.errors++;
		end
		$display("Covered %0d requests and %0d results over %0d register settings.",
			sb.requests, sb.results, settings_loaded);
		$display("Runs ended: ok %0d, stop %0d, timeout %0d, no light %0d, too high %0d.",
			sb.ended[int'(ST_OK)], sb.ended[int'(ST_STOP)], sb.ended[int'(ST_TIMEOUT)],
			sb.ended[int'(ST_NOLIGHT)], sb.ended[int'(ST_HIGH)]);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
